// File: rtl/hrlc_pkg.sv
// Shared constants and types for the HTTP request line checker.
package hrlc_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_T     = 8'h54;

    localparam logic [1:0] VERDICT_OK      = 2'd0;
    localparam logic [1:0] VERDICT_BAD     = 2'd1;
    localparam logic [1:0] VERDICT_METHOD  = 2'd2;
    localparam logic [1:0] VERDICT_NOTIMPL = 2'd3;

    localparam logic [2:0] METHOD_NONE = 3'd0;
    localparam logic [2:0] METHOD_G    = 3'd1;
    localparam logic [2:0] METHOD_GE   = 3'd2;
    localparam logic [2:0] METHOD_DONE = 3'd3;
    localparam logic [2:0] METHOD_FAIL = 3'd4;

    localparam logic [1:0] SPACE_MAX   = 2'd3;
    localparam logic [1:0] SPACE_TWO   = 2'd2;
    localparam logic [1:0] SPACE_ONE   = 2'd1;
    localparam logic [1:0] SPACE_NONE  = 2'd0;

    typedef struct packed {
        logic [1:0] space_count;
        logic [2:0] method_progress;
        logic       target_started;
        logic       slash_ok;
        logic       quote_seen;
        logic       question_seen;
        logic       dot_in_path;
        logic       prev_was_cr;
        logic       crlf_found;
    } line_state_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic       query_present;
    } result_t;

endpackage

// File: rtl/hrlc_eval.sv
// Per-line state tracking and verdict logic of the request line checker.
module hrlc_eval (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       char_in,
    input  logic             line_end,
    output hrlc_pkg::result_t result
);
    import hrlc_pkg::*;

    line_state_t st_reg;
    line_state_t st_next;

    always_comb
    begin
        st_next = st_reg;
        if (st_reg.prev_was_cr && char_in == CH_LF)
        begin
            st_next.crlf_found = 1'b1;
        end
        st_next.prev_was_cr = (char_in == CH_CR);

        if (char_in == CH_SPACE)
        begin
            if (st_reg.space_count != SPACE_MAX)
            begin
                st_next.space_count = st_reg.space_count + 2'd1;
            end
        end
        else if (st_reg.space_count == SPACE_NONE)
        begin
            // advance the GET match, any miss sticks
            case (st_reg.method_progress)
                METHOD_NONE: st_next.method_progress = (char_in == CH_G) ? METHOD_G : METHOD_FAIL;
                METHOD_G:    st_next.method_progress = (char_in == CH_E) ? METHOD_GE : METHOD_FAIL;
                METHOD_GE:   st_next.method_progress = (char_in == CH_T) ? METHOD_DONE
                                                                         : METHOD_FAIL;
                default:     st_next.method_progress = METHOD_FAIL;
            endcase
        end
        else if (st_reg.space_count == SPACE_ONE)
        begin
            if (!st_reg.target_started)
            begin
                st_next.slash_ok       = (char_in == CH_SLASH);
                st_next.target_started = 1'b1;
            end
            if (char_in == CH_QUOTE)
            begin
                st_next.quote_seen = 1'b1;
            end
            if (char_in == CH_QMARK)
            begin
                st_next.question_seen = 1'b1;
            end
            if (char_in == CH_DOT && !st_reg.question_seen)
            begin
                st_next.dot_in_path = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (st_next.space_count != SPACE_TWO)
            result.verdict = VERDICT_BAD;
        else if (!st_next.crlf_found)
            result.verdict = VERDICT_BAD;
        else if (st_next.method_progress != METHOD_DONE)
            result.verdict = VERDICT_METHOD;
        else if (!st_next.slash_ok)
            result.verdict = VERDICT_NOTIMPL;
        else if (st_next.quote_seen)
            result.verdict = VERDICT_BAD;
        else if (!st_next.dot_in_path)
            result.verdict = VERDICT_NOTIMPL;
        else
            result.verdict = VERDICT_OK;
        result.query_present = (result.verdict == VERDICT_OK) && st_next.question_seen;
    end

    // clear everything after the final beat of a line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (step)
        begin
            st_reg <= line_end ? line_state_t'('0) : st_next;
        end
    end

endmodule

// File: rtl/http_request_line_checker.sv
// Top level of the HTTP request line checker: input stage, checker, result register.
//
//  channel  | direction | beat contents
//  ---------+-----------+----------------------------------------------------
//  s_*      | in        | tdata = char_in[7:0]; tlast = line_end
//  m_*      | out       | tdata = verdict[1:0], query_present[2], zero[7:3]
//
// One byte per cycle sustained, except while a last byte waits for a stalled result.
// Each byte passes the input register, the flag update logic and, on the last byte,
// the result register. rst_n clears all line state and empties both registers.
// A stalled result blocks only a last byte; earlier bytes flow, bytes behind it wait.
module http_request_line_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // char_in[7:0]
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // verdict[1:0], query_present[2], zero[7:3]
);
    import hrlc_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    result_t    out_result_reg;
    result_t    eval_result;
    logic       out_free;
    logic       advance;

    assign out_free = !out_valid_reg || m_tready;
    // a last byte needs room in the result register
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    hrlc_eval u_eval (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .char_in  (in_char_reg),
        .line_end (in_last_reg),
        .result   (eval_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_result_reg <= eval_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_result_reg.query_present, out_result_reg.verdict};

`ifndef SYNTHESIS
    a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");

    a_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && in_last_reg && out_valid_reg && !m_tready)
            |=> (in_valid_reg && in_last_reg && $stable(in_char_reg)))
        else $error("last byte left the input stage while result stalled");

    a_query_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_result_reg.query_present
                           || out_result_reg.verdict == VERDICT_OK))
        else $error("query flag set on a failed line");
`endif

endmodule
